FILE: src/ffra_pkg.sv
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared constants, payload types and search functions of the first-free
// room allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

    // Room set and field widths
    localparam int ROOM_COUNT = 256;
    localparam int ROOM_W     = 16;
    localparam int OWNER_W    = 32;
    localparam int TYPE_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int SPAN_W     = ROOM_W + 1;

    // Occupancy memory geometry: one row holds ROW_W occupied bits
    localparam int ROW_W      = 16;
    localparam int BIT_IDX_W  = $clog2(ROW_W);
    localparam int ROW_COUNT  = (ROOM_COUNT + ROW_W - 1) / ROW_W;
    localparam int ROW_IDX_W  = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int ROW_SPACE  = 1 << ROW_IDX_W;
    localparam int SLOT_W     = ROW_IDX_W + BIT_IDX_W;
    localparam int SLOT_SPACE = 1 << SLOT_W;

    localparam logic [ROOM_W-1:0] RESET_FIRST_ROOM = 16'd89;

    // Request codes
    localparam logic [TYPE_W-1:0] REQ_ALLOC   = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_CLAIM   = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_RELEASE = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic [TYPE_W-1:0]  req_type;
        logic [OWNER_W-1:0] owner_id;
        logic [ROOM_W-1:0]  room_number;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ROOM_W-1:0]   granted_room;
        logic                was_occupied;
    } t_res;

    // Occupancy store command: one row read, one row write back
    typedef struct packed {
        logic                 rd_en;
        logic [ROW_IDX_W-1:0] rd_row;
        logic                 wr_en;
        logic [ROW_IDX_W-1:0] wr_row;
        logic [ROW_W-1:0]     wr_word;
    } t_occ_cmd;

    // Lowest clear bit of one occupancy row
    function automatic logic [BIT_IDX_W-1:0] first_zero_bit(input logic [ROW_W-1:0] word);
        logic [BIT_IDX_W-1:0] idx;
        idx = '0;
        for (int i = ROW_W - 1; i >= 0; i--) begin
            if (!word[i]) begin
                idx = BIT_IDX_W'(i);
            end
        end
        return idx;
    endfunction

    // Lowest row that still has a vacant room
    function automatic logic [ROW_IDX_W-1:0] first_open_row(input logic [ROW_COUNT-1:0] full);
        logic [ROW_IDX_W-1:0] idx;
        idx = '0;
        for (int i = ROW_COUNT - 1; i >= 0; i--) begin
            if (!full[i]) begin
                idx = ROW_IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

FILE: src/ffra_ram.sv
// ----------------------------------------------------------------------------
// ffra_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ffra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/ffra_occ.sv
// ----------------------------------------------------------------------------
// ffra_occ
// Occupancy store: rows of occupied bits in RAM, per-row valid and full
// flags in flops, and the search for the lowest row with a vacancy.
// ----------------------------------------------------------------------------
module ffra_occ (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ffra_pkg::t_occ_cmd             i_cmd,
    output logic [ffra_pkg::ROW_W-1:0]     o_rd_word,
    output logic [ffra_pkg::ROW_IDX_W-1:0] o_open_row,
    output logic                           o_any_open
);
    import ffra_pkg::*;

    logic [ROW_COUNT-1:0] r_row_vld;
    logic [ROW_COUNT-1:0] r_row_full;
    logic                 r_rd_vld;
    logic [ROW_W-1:0]     ram_q;

    ffra_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROW_SPACE)
    ) u_occ_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (i_cmd.wr_row),
        .i_wr_data (i_cmd.wr_word),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (i_cmd.rd_row),
        .o_rd_data (ram_q)
    );

    // A row never written since reset reads as all vacant
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld  <= '0;
            r_row_full <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            if (i_cmd.rd_en) begin
                r_rd_vld <= r_row_vld[i_cmd.rd_row];
            end
            if (i_cmd.wr_en) begin
                r_row_vld[i_cmd.wr_row]  <= 1'b1;
                r_row_full[i_cmd.wr_row] <= &i_cmd.wr_word;
            end
        end
    end

    assign o_rd_word  = r_rd_vld ? ram_q : '0;
    assign o_open_row = first_open_row(r_row_full);
    assign o_any_open = ~&r_row_full;

endmodule

FILE: src/first_free_room_allocator_core.sv
// ----------------------------------------------------------------------------
// first_free_room_allocator_core
// First-fit room allocator: allocate the lowest vacant room, claim a named
// room, or release a named room; one result per request.
// ----------------------------------------------------------------------------
//
//  Channel   | Ports                          | Transfer
//  ----------+--------------------------------+--------------------------------
//  request   | start, busy, i_req             | edge with start high, busy low
//  result    | o_res_stb, o_res               | edge ending the strobe cycle
//  config    | i_cfg_wr_en, i_cfg_wr_data     | edge with i_cfg_wr_en high
//
//  Sequencing: after the transfer, busy stays high through the row lookup,
//  then the read-modify-write of one occupancy row, and a new request is
//  taken only once busy drops again. The occupancy RAM's single read and
//  write per request set this order.
//  Reset: synchronous, active low; every room reads vacant right after reset,
//  no clearing pass. First room number returns to 89.
//  Stalls: the result side cannot stall; the result is shown for one cycle.
// ----------------------------------------------------------------------------
module first_free_room_allocator_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  ffra_pkg::t_req              i_req,
    output logic                        o_res_stb,
    output ffra_pkg::t_res              o_res,
    input  logic                        i_cfg_wr_en,
    input  logic [ffra_pkg::ROOM_W-1:0] i_cfg_wr_data
);
    import ffra_pkg::*;

    // Control and held request
    t_state                r_state, n_state;
    t_req                  r_req, n_req;
    logic [ROOM_W-1:0]     r_base;
    logic [ROW_IDX_W-1:0]  r_row, n_row;
    logic [BIT_IDX_W-1:0]  r_bit, n_bit;
    logic                  r_bad, n_bad;
    logic                  r_any_open, n_any_open;
    logic                  r_res_stb, n_res_stb;
    t_res                  r_res, n_res;

    // Occupancy store interface
    t_occ_cmd              occ_cmd;
    logic [ROW_W-1:0]      occ_word;
    logic [ROW_IDX_W-1:0]  open_row;
    logic                  any_open;

    // Owner memory write port
    logic                  own_wr_en;
    logic [SLOT_W-1:0]     own_wr_addr;

    // Range arithmetic
    logic [SPAN_W-1:0]     span;
    logic [SPAN_W-1:0]     limit;
    logic [SPAN_W-1:0]     offset;
    logic [BIT_IDX_W-1:0]  free_bit;
    logic [SLOT_W-1:0]     alloc_slot;
    logic [SLOT_W-1:0]     named_slot;
    logic                  alloc_ok;

    ffra_occ u_occ (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (occ_cmd),
        .o_rd_word  (occ_word),
        .o_open_row (open_row),
        .o_any_open (any_open)
    );

    // Owner ids are stored for the record; nothing reads them back
    ffra_ram #(
        .WIDTH (OWNER_W),
        .DEPTH (SLOT_SPACE)
    ) u_owner_ram (
        .i_clk     (i_clk),
        .i_wr_en   (own_wr_en),
        .i_wr_addr (own_wr_addr),
        .i_wr_data (r_req.owner_id),
        .i_rd_en   (1'b0),
        .i_rd_addr ('0),
        .o_rd_data ()
    );

    // Usable slots: rooms whose number still fits in 16 bits
    assign span   = SPAN_W'(1 << ROOM_W) - {1'b0, r_base};
    assign limit  = (span < SPAN_W'(ROOM_COUNT)) ? span : SPAN_W'(ROOM_COUNT);
    // Borrow in the top bit flags a room below the base
    assign offset = {1'b0, r_req.room_number} - {1'b0, r_base};

    assign free_bit   = first_zero_bit(occ_word);
    assign alloc_slot = {r_row, free_bit};
    assign named_slot = {r_row, r_bit};
    assign alloc_ok   = r_any_open && ({{(SPAN_W - SLOT_W){1'b0}}, alloc_slot} < limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_base    <= RESET_FIRST_ROOM;
            r_res_stb <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_res_stb <= n_res_stb;
            if (i_cfg_wr_en) begin
                r_base <= i_cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_row      <= n_row;
        r_bit      <= n_bit;
        r_bad      <= n_bad;
        r_any_open <= n_any_open;
        r_res      <= n_res;
    end

    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_row      = r_row;
        n_bit      = r_bit;
        n_bad      = r_bad;
        n_any_open = r_any_open;
        n_res_stb  = 1'b0;
        n_res      = r_res;
        busy       = 1'b1;
        occ_cmd    = '0;
        own_wr_en  = 1'b0;
        own_wr_addr = named_slot;

        unique case (r_state)
            S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    n_req   = i_req;
                    n_state = S_LOOK;
                end
            end

            // Pick the row: first open row for allocate, the named row otherwise
            S_LOOK: begin
                n_any_open = any_open;
                n_bit      = offset[BIT_IDX_W-1:0];
                if (r_req.req_type == REQ_ALLOC) begin
                    n_row = open_row;
                    n_bad = 1'b0;
                end else begin
                    n_row = offset[SLOT_W-1:BIT_IDX_W];
                    n_bad = (r_req.req_type != REQ_CLAIM && r_req.req_type != REQ_RELEASE)
                            || offset[SPAN_W-1] || (offset >= limit);
                end
                occ_cmd.rd_en  = 1'b1;
                occ_cmd.rd_row = n_row;
                n_state        = S_UPDATE;
            end

            // Row data is back: modify, write back, post the result
            S_UPDATE: begin
                n_res_stb      = 1'b1;
                n_res          = '{status: ST_RANGE, granted_room: '0, was_occupied: 1'b0};
                occ_cmd.wr_row = r_row;
                unique case (r_req.req_type) inside
                    REQ_ALLOC: begin
                        if (alloc_ok) begin
                            occ_cmd.wr_en   = 1'b1;
                            occ_cmd.wr_word = occ_word | (ROW_W'(1) << free_bit);
                            own_wr_en       = 1'b1;
                            own_wr_addr     = alloc_slot;
                            n_res.status       = ST_OK;
                            n_res.granted_room = r_base + ROOM_W'(alloc_slot);
                        end else begin
                            n_res.status = ST_FULL;
                        end
                    end
                    REQ_CLAIM, REQ_RELEASE: begin
                        if (!r_bad) begin
                            occ_cmd.wr_en = 1'b1;
                            if (r_req.req_type == REQ_CLAIM) begin
                                occ_cmd.wr_word = occ_word | (ROW_W'(1) << r_bit);
                                own_wr_en       = 1'b1;
                            end else begin
                                occ_cmd.wr_word = occ_word & ~(ROW_W'(1) << r_bit);
                            end
                            n_res.status       = ST_OK;
                            n_res.granted_room = r_req.room_number;
                            n_res.was_occupied = occ_word[r_bit];
                        end
                    end
                    default: begin
                        // unknown request: flagged out of range, no change
                    end
                endcase
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res_stb = r_res_stb;
    assign o_res     = r_res;

endmodule

FILE: test/ffra_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ffra_checker
// Watches the request, result and base-register channels of the room
// allocator, keeps its own occupancy picture, and compares every result.
// ----------------------------------------------------------------------------
module ffra_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_busy,
    input  ffra_pkg::t_req              i_req,
    input  logic                        i_res_stb,
    input  ffra_pkg::t_res              i_res,
    input  logic                        i_cfg_wr_en,
    input  logic [ffra_pkg::ROOM_W-1:0] i_cfg_wr_data,
    output int                          o_pending,
    output int                          o_fail_count,
    output int                          o_result_count,
    output int                          o_full_count,
    output int                          o_range_count
);
    import ffra_pkg::*;

    logic               room_taken [ROOM_COUNT];
    logic [ROOM_W-1:0]  base_room;
    t_res               awaited_q [$];
    int                 fail_count   = 0;
    int                 result_count = 0;
    int                 full_count   = 0;
    int                 range_count  = 0;

    // Rooms whose number still fits in 16 bits
    function automatic int usable_rooms();
        int span;
        span = 65536 - int'(base_room);
        return (span < ROOM_COUNT) ? span : ROOM_COUNT;
    endfunction

    // Apply one request to the occupancy picture and return its result
    function automatic t_res serve_request(input t_req req);
        t_res res;
        int   lim;
        int   slot;
        res = '0;
        lim = usable_rooms();
        case (req.req_type) inside
            REQ_ALLOC: begin
                res.status = ST_FULL;
                for (slot = 0; slot < lim && res.status == ST_FULL; slot++) begin
                    if (!room_taken[slot]) begin
                        room_taken[slot] = 1'b1;
                        res.status       = ST_OK;
                        res.granted_room = base_room + ROOM_W'(slot);
                    end
                end
            end
            REQ_CLAIM, REQ_RELEASE: begin
                slot = int'(req.room_number) - int'(base_room);
                if (slot < 0 || slot >= lim) begin
                    res.status = ST_RANGE;
                end else begin
                    res.granted_room = req.room_number;
                    res.was_occupied = room_taken[slot];
                    if (req.req_type == REQ_CLAIM) begin
                        room_taken[slot] = 1'b1;
                    end else begin
                        room_taken[slot] = 1'b0;
                    end
                end
            end
            default: begin
                res.status = ST_RANGE;
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_res want;
        if (!i_rst_n) begin
            for (int i = 0; i < ROOM_COUNT; i++) begin
                room_taken[i] = 1'b0;
            end
            base_room = RESET_FIRST_ROOM;
            awaited_q.delete();
        end else begin
            // Retire the oldest expectation before queueing a new one
            if (i_res_stb) begin
                result_count++;
                if (awaited_q.size() == 0) begin
                    $error("result with nothing outstanding: status %0d room %0d",
                           i_res.status, i_res.granted_room);
                    fail_count++;
                end else begin
                    want = awaited_q.pop_front();
                    if (want.status == ST_FULL) full_count++;
                    if (want.status == ST_RANGE) range_count++;
                    if (i_res.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_res.status);
                        fail_count++;
                    end
                    if (i_res.granted_room !== want.granted_room) begin
                        $error("granted_room: expected %0d, got %0d",
                               want.granted_room, i_res.granted_room);
                        fail_count++;
                    end
                    if (i_res.was_occupied !== want.was_occupied) begin
                        $error("was_occupied: expected %0d, got %0d",
                               want.was_occupied, i_res.was_occupied);
                        fail_count++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                awaited_q.push_back(serve_request(i_req));
            end
            if (i_cfg_wr_en) begin
                base_room = i_cfg_wr_data;
            end
        end
        o_pending      <= awaited_q.size();
        o_fail_count   <= fail_count;
        o_result_count <= result_count;
        o_full_count   <= full_count;
        o_range_count  <= range_count;
    end

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives requests and base-register writes into the first-free room
// allocator: a short directed pass over the corner cases, then random
// phases at several room bases and idle mixes. A checker beside the block
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    import ffra_pkg::*;

    // Request code the block does not define; it must answer out of range
    localparam logic [TYPE_W-1:0] REQ_BOGUS = 2'd3;
    localparam int RESULT_LATENCY = 3;
    localparam int STALL_LIMIT    = 1000;
    localparam int PHASE_COUNT    = 6;
    localparam int RANDOM_BASE    = -1;

    // Per phase: room base, sender idle percent, allocate percent, requests
    localparam int PHASE_BASE  [PHASE_COUNT] = '{89, 65535, 0, 65500, 65280, RANDOM_BASE};
    localparam int PHASE_IDLE  [PHASE_COUNT] = '{0, 54, 23, 54, 0, 23};
    localparam int PHASE_ALLOC [PHASE_COUNT] = '{85, 40, 60, 50, 55, 50};
    localparam int PHASE_ITEMS [PHASE_COUNT] = '{300, 60, 300, 150, 200, 190};

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              start       = 1'b0;
    logic              busy;
    t_req              req         = '0;
    logic              res_stb;
    t_res              res;
    logic              cfg_wr_en   = 1'b0;
    logic [ROOM_W-1:0] cfg_wr_data = '0;

    int                fail_count;
    int                pending;
    int                result_count;
    int                full_count;
    int                range_count;
    int                idle_pct     = 0;
    int                sent_count   = 0;
    int                base_count   = 0;
    int                quiet_cycles = 0;
    logic [ROOM_W-1:0] cur_base     = RESET_FIRST_ROOM;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    first_free_room_allocator_core u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .start         (start),
        .busy          (busy),
        .i_req         (req),
        .o_res_stb     (res_stb),
        .o_res         (res),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    ffra_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_req          (req),
        .i_res_stb      (res_stb),
        .i_res          (res),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .o_pending      (pending),
        .o_fail_count   (fail_count),
        .o_result_count (result_count),
        .o_full_count   (full_count),
        .o_range_count  (range_count)
    );

    // Watchdog: end the run once nothing has moved on either channel
    // for too long (a lost result or a busy that never drops).
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || res_stb) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Number of rooms reachable from a given base (room numbers stop at 65535)
    function automatic int room_span(input logic [ROOM_W-1:0] base);
        int span;
        span = 65536 - int'(base);
        return (span < ROOM_COUNT) ? span : ROOM_COUNT;
    endfunction

    function automatic t_req make_request(input logic [TYPE_W-1:0]  kind,
                                          input logic [OWNER_W-1:0] owner,
                                          input logic [ROOM_W-1:0]  room);
        t_req r;
        r.req_type    = kind;
        r.owner_id    = owner;
        r.room_number = room;
        return r;
    endfunction

    // Random request: mostly rooms inside the current window, weighted to
    // the low slots where allocations land, plus the window edges and noise.
    function automatic t_req pick_request(input int alloc_pct);
        t_req r;
        int   span;
        int   roll;
        span          = room_span(cur_base);
        r.owner_id    = $urandom;
        r.room_number = ROOM_W'($urandom);
        roll          = $urandom_range(0, 99);
        if (roll < alloc_pct) begin
            r.req_type = REQ_ALLOC;
        end else begin
            roll = $urandom_range(0, 19);
            if (roll < 9) begin
                r.req_type = REQ_CLAIM;
            end else if (roll < 18) begin
                r.req_type = REQ_RELEASE;
            end else begin
                r.req_type = REQ_BOGUS;
            end
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    r.room_number = cur_base + ROOM_W'($urandom_range(0, span - 1));
                end
                3, 4, 5: begin
                    r.room_number = cur_base +
                                    ROOM_W'($urandom_range(0, ((span < 32) ? span : 32) - 1));
                end
                6: begin
                    r.room_number = cur_base - 1'b1;
                end
                7: begin
                    r.room_number = cur_base + ROOM_W'(span);
                end
                8: begin
                    r.room_number = cur_base + ROOM_W'(span - 1);
                end
                default: begin
                    // keep the fully random room number
                end
            endcase
        end
        return r;
    endfunction

    // Present one request and hold it until the block takes it. Leave start
    // high for back-to-back transfers; drop it only when a gap is drawn.
    task automatic send_request(input t_req r);
        req   <= r;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        sent_count++;
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Stop issuing, wait for every outstanding result, then let the
    // pipeline settle so the block is idle for a register write.
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (RESULT_LATENCY + 2) @(posedge clk);
    endtask

    task automatic set_base(input logic [ROOM_W-1:0] base);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= base;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cur_base   = base;
        base_count++;
    endtask

    initial begin
        // Hold reset, then release it at an edge
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pass at the reset base: first fit, claim over an owner,
        // the last usable room, both window edges, double release, bad code.
        send_request(make_request(REQ_ALLOC,   32'h0000_0000, 16'h0000));
        send_request(make_request(REQ_ALLOC,   32'hFFFF_FFFF, 16'hFFFF));
        send_request(make_request(REQ_CLAIM,   32'hA5A5_A5A5, 16'd89));
        send_request(make_request(REQ_CLAIM,   32'h0000_0001, 16'd88));
        send_request(make_request(REQ_CLAIM,   32'h0000_0002, 16'd344));
        send_request(make_request(REQ_CLAIM,   32'h0000_0003, 16'd345));
        send_request(make_request(REQ_RELEASE, 32'h0000_0000, 16'd90));
        send_request(make_request(REQ_RELEASE, 32'h0000_0000, 16'd90));
        send_request(make_request(REQ_RELEASE, 32'h0000_0000, 16'd0));
        send_request(make_request(REQ_RELEASE, 32'h0000_0000, 16'hFFFF));
        send_request(make_request(REQ_BOGUS,   32'h5A5A_5A5A, 16'd89));
        send_request(make_request(REQ_ALLOC,   32'h0000_0007, 16'd0));
        send_request(make_request(REQ_RELEASE, 32'h0000_0000, 16'd344));

        // Top base: a single usable room, already held by slot zero, so
        // allocate must report every room taken until it is released.
        drain();
        set_base(16'hFFFF);
        send_request(make_request(REQ_ALLOC,   32'h1234_5678, 16'd0));
        send_request(make_request(REQ_RELEASE, 32'h0000_0000, 16'hFFFF));
        send_request(make_request(REQ_ALLOC,   32'h8765_4321, 16'd0));
        send_request(make_request(REQ_CLAIM,   32'h0000_0009, 16'hFFFE));
        send_request(make_request(REQ_ALLOC,   32'hCAFE_0001, 16'd0));

        // Zero base: room numbers equal slot indexes; the occupancy moves
        // along with the new mapping.
        drain();
        set_base(16'h0000);
        send_request(make_request(REQ_CLAIM,   32'h0000_0000, 16'd0));
        send_request(make_request(REQ_RELEASE, 32'h0000_0000, 16'd255));
        send_request(make_request(REQ_CLAIM,   32'hFFFF_FFFF, 16'd256));
        send_request(make_request(REQ_BOGUS,   32'h0000_0000, 16'd0));

        // Random phases, each at its own base and idle mix
        for (int p = 0; p < PHASE_COUNT; p++) begin
            drain();
            if (PHASE_BASE[p] == RANDOM_BASE) begin
                set_base(ROOM_W'($urandom_range(0, 65535)));
            end else begin
                set_base(ROOM_W'(PHASE_BASE[p]));
            end
            idle_pct = PHASE_IDLE[p];
            for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
                send_request(pick_request(PHASE_ALLOC[p]));
            end
        end
        drain();

        $display("Sent %0d requests over %0d room-base settings, idle mixes 0/23/54 percent.",
                 sent_count, base_count);
        $display("Compared %0d results: %0d with every room taken, %0d out of range.",
                 result_count, full_count, range_count);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
src/ffra_pkg.sv
src/ffra_ram.sv
src/ffra_occ.sv
src/first_free_room_allocator_core.sv
test/ffra_checker.sv
test/tb.sv
